FILE: rtl/isr_pkg.sv
// Package for the indexed stack with roll: sizes, request structs, mode,
// status and cell command codes. No dependencies.
`default_nettype none
package isr_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMP_W     = (CNT_W > 6) ? CNT_W : 6;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [IDX_W-1:0]     t_pos;
    typedef logic [CNT_W-1:0]     t_cnt;

    localparam logic [2:0] MODE_PUSH    = 3'd0;
    localparam logic [2:0] MODE_POP     = 3'd1;
    localparam logic [2:0] MODE_PEEK    = 3'd2;
    localparam logic [2:0] MODE_POKE    = 3'd3;
    localparam logic [2:0] MODE_EXTRACT = 3'd4;
    localparam logic [2:0] MODE_INSERT  = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADIDX = 2'd1;
    localparam logic [1:0] ST_UNDER  = 2'd2;
    localparam logic [1:0] ST_OVER   = 2'd3;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_EXTRACT = 2'd2;
    localparam logic [1:0] CMD_INSERT  = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  index;
        logic [31:0] value;
    } t_in_req;

    typedef struct packed {
        logic [31:0] read_word;
        logic [1:0]  status;
        logic [6:0]  depth_now;
    } t_out_req;

    typedef struct packed {
        logic [1:0] cmd;
        t_pos       lo;
        t_pos       hi;
        t_pos       addr;
        t_word      wdata;
        t_word      tword;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: rtl/isr_cell.sv
// One stack cell: holds one entry, shifts from either neighbor on a roll,
// loads a written word or the moved word. Depends on isr_pkg.
`default_nettype none
module isr_cell
    import isr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_pos      i_raddr,
    input  wire t_pos      i_pos,
    input  wire t_word     i_above,
    input  wire t_word     i_below,
    output t_word          o_word,
    output t_word          o_rd
);

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctl.cmd)
            CMD_WRITE: begin
                if (i_pos == i_ctl.addr) n_word = i_ctl.wdata;
            end
            CMD_EXTRACT: begin
                if (i_pos == i_ctl.hi) begin
                    n_word = i_ctl.tword;
                end else if (i_pos >= i_ctl.lo && i_pos < i_ctl.hi) begin
                    n_word = i_above;
                end
            end
            CMD_INSERT: begin
                if (i_pos == i_ctl.lo) begin
                    n_word = i_ctl.tword;
                end else if (i_pos > i_ctl.lo && i_pos <= i_ctl.hi) begin
                    n_word = i_below;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_rd   = (i_pos == i_raddr) ? r_word : '0;

endmodule
`default_nettype wire

FILE: rtl/indexed_stack_with_roll_unit.sv
// Top level of the indexed stack with roll: request decode, count, row of
// isr_cell entries, read bus and result register. Depends on isr_pkg, isr_cell.
//
//  channel | direction | payload   | handshake
//  in      | request   | t_in_req  | i_in_valid / o_in_stall
//  out     | result    | t_out_req | o_out_valid / i_out_stall
//
// One request per cycle unless the output stalls: a request updates the cell
// row when accepted, and its result sits in the output register the next cycle.
// Rolls shift every cell between index and top at once through the chain.
// A new request is taken while the result register is empty or being taken.
// Reset clears the count and the result valid; entries are not cleared.
`default_nettype none
module indexed_stack_with_roll_unit
    import isr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_in_req i_in_req,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_req     o_out_req
);

    t_cnt      r_count;
    t_cnt      n_count;
    logic      r_out_valid;
    t_out_req  r_out;
    t_out_req  n_out;
    t_cell_ctl ctl;
    t_pos      raddr;
    t_pos      idx_p;
    t_pos      top_p;
    t_word     rd_bus;
    logic      accept;
    logic      idx_ok;
    logic      full;
    logic      empty;
    t_word     cell_word [DEPTH];
    t_word     cell_rd   [DEPTH];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign idx_p  = t_pos'(i_in_req.index);
    assign top_p  = t_pos'(r_count - t_cnt'(1));
    assign idx_ok = CMP_W'(i_in_req.index) < CMP_W'(r_count);
    assign full   = r_count == t_cnt'(DEPTH);
    assign empty  = r_count == '0;
    assign raddr  = (i_in_req.mode == MODE_POP || i_in_req.mode == MODE_INSERT)
                    ? top_p : idx_p;

    always_comb begin
        rd_bus = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    always_comb begin
        n_count         = r_count;
        ctl.cmd         = CMD_NONE;
        ctl.lo          = idx_p;
        ctl.hi          = top_p;
        ctl.addr        = idx_p;
        ctl.wdata       = t_word'(i_in_req.value);
        ctl.tword       = rd_bus;
        n_out.read_word = '0;
        n_out.status    = ST_OK;
        case (i_in_req.mode)
            MODE_PUSH: begin
                if (full) begin
                    n_out.status = ST_OVER;
                end else begin
                    ctl.cmd  = CMD_WRITE;
                    ctl.addr = t_pos'(r_count);
                    n_count  = r_count + t_cnt'(1);
                end
            end
            MODE_POP: begin
                if (empty) begin
                    n_out.status = ST_UNDER;
                end else begin
                    n_count         = r_count - t_cnt'(1);
                    n_out.read_word = 32'(rd_bus);
                end
            end
            MODE_PEEK: begin
                if (!idx_ok) n_out.status = ST_BADIDX;
                else n_out.read_word = 32'(rd_bus);
            end
            MODE_POKE: begin
                if (!idx_ok) n_out.status = ST_BADIDX;
                else ctl.cmd = CMD_WRITE;
            end
            MODE_EXTRACT: begin
                if (!idx_ok) n_out.status = ST_BADIDX;
                else ctl.cmd = CMD_EXTRACT;
            end
            MODE_INSERT: begin
                if (!idx_ok) n_out.status = ST_BADIDX;
                else ctl.cmd = CMD_INSERT;
            end
            default: ctl.cmd = CMD_NONE;
        endcase
        if (!accept) begin
            ctl.cmd = CMD_NONE;
            n_count = r_count;
        end
        n_out.depth_now = 7'(n_count);
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            isr_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_raddr (raddr),
                .i_pos   (t_pos'(g)),
                .i_above ((g == DEPTH - 1) ? t_word'(0) : cell_word[(g + 1) % DEPTH]),
                .i_below ((g == 0) ? t_word'(0) : cell_word[(g + DEPTH - 1) % DEPTH]),
                .o_word  (cell_word[g]),
                .o_rd    (cell_rd[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule
`default_nettype wire
